@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the culling core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define FBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define FBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/fbc_pkg.sv @@
// ---------------------------------------------------------------------------
// Frustum box cull package
// Widths, register indexes and shared types of the culling core.
// ---------------------------------------------------------------------------
package fbc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_REGS   = 8;
    localparam int CFG_W      = 64;
    localparam int IDX_W      = 3;
    localparam int COORD_W    = 32;
    localparam int COEF_W     = COORD_W + 1;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int W_SHIFT    = 16;
    localparam int LATENCY    = 2 * NUM_PLANES + 1;

    localparam logic [IDX_W-1:0] REG_ROW0_XY = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_ZW = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_XY = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_ZW = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_XY = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_ZW = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_XY = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_ZW = 3'd7;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef x;
        t_coef y;
        t_coef z;
        t_coef w;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        logic valid;
        logic in_view;
    } t_ctl;

endpackage

@@ rtl/core/fbc_cfg.sv @@
// ---------------------------------------------------------------------------
// Frustum box cull configuration
// Clip matrix registers and the six registered frustum planes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fbc_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fbc_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [fbc_pkg::CFG_W-1:0] i_cfg_data,
    output fbc_pkg::t_plane           o_plane [fbc_pkg::NUM_PLANES]
);
    import fbc_pkg::*;

    logic [CFG_W-1:0] r_reg [NUM_REGS];
    t_plane           r_plane [NUM_PLANES];
    t_plane           n_plane [NUM_PLANES];
    t_plane           row [4];

    function automatic t_coef ext(input logic [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    function automatic t_plane combine(input t_plane a, input t_plane b, input logic sub);
        t_plane p;
        p.x = sub ? a.x - b.x : a.x + b.x;
        p.y = sub ? a.y - b.y : a.y + b.y;
        p.z = sub ? a.z - b.z : a.z + b.z;
        p.w = sub ? a.w - b.w : a.w + b.w;
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_reg[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_reg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            row[r].x = ext(r_reg[2*r][CFG_W-1:COORD_W]);
            row[r].y = ext(r_reg[2*r][COORD_W-1:0]);
            row[r].z = ext(r_reg[2*r+1][CFG_W-1:COORD_W]);
            row[r].w = ext(r_reg[2*r+1][COORD_W-1:0]);
        end
        n_plane[0] = combine(row[3], row[0], 1'b0);
        n_plane[1] = combine(row[3], row[0], 1'b1);
        n_plane[2] = combine(row[3], row[1], 1'b0);
        n_plane[3] = combine(row[3], row[1], 1'b1);
        n_plane[4] = row[2];
        n_plane[5] = combine(row[3], row[2], 1'b1);
    end

    always_ff @(posedge i_clk) begin
        r_plane <= n_plane;
    end

    assign o_plane = r_plane;

    `FBC_ASSERT(a_row3_write, i_clk, i_rst_n,
        (i_cfg_we && i_cfg_idx == REG_ROW3_ZW) |=> (r_reg[REG_ROW3_ZW] == $past(i_cfg_data)),
        "row 3 zw register missed a write")

endmodule

@@ rtl/core/fbc_cell.sv @@
// ---------------------------------------------------------------------------
// Frustum box cull cell
// Two-stage test of one plane against the positive corner of a box.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fbc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fbc_pkg::t_plane i_plane,
    input  fbc_pkg::t_ctl   i_ctl,
    input  fbc_pkg::t_box   i_box,
    output fbc_pkg::t_ctl   o_ctl,
    output fbc_pkg::t_box   o_box
);
    import fbc_pkg::*;

    logic signed [COORD_W-1:0] px, py, pz;
    logic signed [PROD_W-1:0]  n_prod [3];
    logic signed [PROD_W-1:0]  r_prod [3];
    logic signed [SUM_W-1:0]   sum;
    t_ctl                      r_ctl1, r_ctl2;
    t_box                      r_box1, r_box2;

    always_comb begin
        px = i_plane.x[COEF_W-1] ? i_box.min_x : i_box.max_x;
        py = i_plane.y[COEF_W-1] ? i_box.min_y : i_box.max_y;
        pz = i_plane.z[COEF_W-1] ? i_box.min_z : i_box.max_z;
        n_prod[0] = PROD_W'(i_plane.x) * PROD_W'(px);
        n_prod[1] = PROD_W'(i_plane.y) * PROD_W'(py);
        n_prod[2] = PROD_W'(i_plane.z) * PROD_W'(pz);
        sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
            + (SUM_W'(i_plane.w) <<< W_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1         <= i_ctl;
            r_ctl2.valid   <= r_ctl1.valid;
            r_ctl2.in_view <= r_ctl1.in_view & ~sum[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_box1 <= i_box;
        r_box2 <= r_box1;
    end

    assign o_ctl = r_ctl2;
    assign o_box = r_box2;

    `FBC_ASSERT(a_inside_only_clears, i_clk, i_rst_n,
        (o_ctl.valid && o_ctl.in_view) |-> $past(i_ctl.in_view, 2),
        "cell set inside on an item that arrived outside")

    `FBC_ASSERT(a_valid_follows, i_clk, i_rst_n,
        o_ctl.valid |-> $past(i_ctl.valid, 2),
        "cell produced an item it never received")

endmodule

@@ rtl/core/frustum_box_cull_top.sv @@
// ---------------------------------------------------------------------------
// Frustum box cull top level
// Tests boxes against six clip planes through a chain of plane cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   box in   | start && !busy       | i_box_min_{x,y,z}, i_box_max_{x,y,z}
//   result   | o_done (one cycle)   | o_inside_res
//   config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One item per cycle while busy is low; each result strobes after one
// input register and two stages in each of the six plane cells.
// Reset is synchronous; busy is high only in the cycle after a reset edge.
// Results cannot be stalled and leave on o_done as they finish.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_box_cull_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          i_box_min_x,
    input  logic signed [31:0]          i_box_min_y,
    input  logic signed [31:0]          i_box_min_z,
    input  logic signed [31:0]          i_box_max_x,
    input  logic signed [31:0]          i_box_max_y,
    input  logic signed [31:0]          i_box_max_z,
    input  logic                        i_cfg_we,
    input  logic [fbc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [fbc_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_done,
    output logic                        o_inside_res
);
    import fbc_pkg::*;

    t_plane plane [NUM_PLANES];
    t_ctl   ctl   [NUM_PLANES+1];
    t_box   box   [NUM_PLANES+1];
    t_ctl   r_ctl;
    t_box   r_box;
    logic   r_busy;

    fbc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_plane    (plane)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_ctl  <= '0;
        end else begin
            r_busy        <= 1'b0;
            r_ctl.valid   <= start & ~r_busy;
            r_ctl.in_view <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box <= '{min_x: i_box_min_x, min_y: i_box_min_y, min_z: i_box_min_z,
                   max_x: i_box_max_x, max_y: i_box_max_y, max_z: i_box_max_z};
    end

    assign ctl[0] = r_ctl;
    assign box[0] = r_box;

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (plane[k]),
            .i_ctl   (ctl[k]),
            .i_box   (box[k]),
            .o_ctl   (ctl[k+1]),
            .o_box   (box[k+1])
        );
    end

    assign busy         = r_busy;
    assign o_done       = ctl[NUM_PLANES].valid;
    assign o_inside_res = ctl[NUM_PLANES].in_view;

    `FBC_ASSERT(a_done_latency, i_clk, i_rst_n,
        o_done |-> $past(start && !busy, LATENCY),
        "result without an accepted item")

    `FBC_ASSERT_ALWAYS(a_busy_after_reset, i_clk,
        !i_rst_n |=> busy,
        "busy low right after reset")

endmodule

@@ tb/frustum_box_cull_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frustum box cull testbench
// Loads clip matrices through the register port, streams boxes in bursts and
// checks every inside flag against a row's own expected flag or an exact
// fixed-point sign computation of the six clip planes. A directed table covers
// the frustum faces, touching corners, inverted boxes, zero normals and coordinate
// and matrix extremes; random phases follow with new matrices each time.
// ---------------------------------------------------------------------------
module frustum_box_cull_top_tb;
    import fbc_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int STALL_LIMIT     = 2000;
    localparam int DSUM_W          = SUM_W + 8;
    localparam int DIR_ROWS        = 25;

    localparam logic signed [COORD_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] Q_HALF  = 32'sh0000_8000;
    localparam logic signed [COORD_W-1:0] Q_QUART = 32'sh0000_4000;
    localparam logic signed [COORD_W-1:0] C_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN   = 32'sh8000_0000;

    localparam t_box BOX_FULL = '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX};
    localparam t_box BOX_INV  = '{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN};
    localparam t_box BOX_ZERO = '{0, 0, 0, 0, 0, 0};

    typedef enum {MAT_ZERO, MAT_UNIT, MAT_NEG_W, MAT_MAX, MAT_MIN} t_mat_sel;
    typedef logic [CFG_W-1:0] t_clip_set [NUM_REGS];

    typedef struct {
        t_mat_sel mat;
        t_box     box;
        bit       known;
        bit       want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_box                 box_drv = '0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic                 o_inside_res;

    t_clip_set            clip_regs = '{default: '0};
    bit                   inside_due [$];
    bit                   box_taken = 1'b0;
    bit                   use_known = 1'b0;
    bit                   known_want = 1'b0;
    bit                   want;
    int                   err_count = 0;
    int                   stall_cycles = 0;
    int                   burst_left = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{MAT_ZERO,  BOX_ZERO, 1'b1, 1'b1},
        '{MAT_ZERO,  BOX_FULL, 1'b1, 1'b1},
        '{MAT_ZERO,  BOX_INV,  1'b1, 1'b1},
        '{MAT_UNIT,  '{-Q_HALF, -Q_HALF, Q_QUART, Q_HALF, Q_HALF, 3*Q_QUART}, 1'b1, 1'b1},
        '{MAT_UNIT,  '{2*Q_ONE, 0, Q_QUART, 3*Q_ONE, Q_HALF, Q_HALF}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{-3*Q_ONE, 0, Q_QUART, -2*Q_ONE, Q_HALF, Q_HALF}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{0, 2*Q_ONE, Q_QUART, Q_HALF, 3*Q_ONE, Q_HALF}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{0, -3*Q_ONE, Q_QUART, Q_HALF, -2*Q_ONE, Q_HALF}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{0, 0, -2*Q_ONE, Q_HALF, Q_HALF, -Q_ONE}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{0, 0, 2*Q_ONE, Q_HALF, Q_HALF, 3*Q_ONE}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{-2*Q_ONE, 0, 0, -Q_ONE, 0, 0}, 1'b1, 1'b1},
        '{MAT_UNIT,  '{-2*Q_ONE, 0, 0, -Q_ONE - 1, 0, 0}, 1'b1, 1'b0},
        '{MAT_UNIT,  '{Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b1, 1'b1},
        '{MAT_UNIT,  '{Q_HALF, 0, Q_QUART, -Q_HALF, 0, Q_QUART}, 1'b0, 1'b0},
        '{MAT_UNIT,  '{3*Q_ONE, 0, Q_QUART, -3*Q_ONE, 0, Q_QUART}, 1'b0, 1'b0},
        '{MAT_UNIT,  BOX_FULL, 1'b1, 1'b1},
        '{MAT_UNIT,  BOX_INV,  1'b0, 1'b0},
        '{MAT_NEG_W, BOX_ZERO, 1'b1, 1'b0},
        '{MAT_NEG_W, BOX_FULL, 1'b1, 1'b0},
        '{MAT_MAX,   BOX_FULL, 1'b0, 1'b0},
        '{MAT_MAX,   BOX_INV,  1'b0, 1'b0},
        '{MAT_MAX,   BOX_ZERO, 1'b0, 1'b0},
        '{MAT_MIN,   BOX_FULL, 1'b0, 1'b0},
        '{MAT_MIN,   BOX_INV,  1'b0, 1'b0},
        '{MAT_MIN,   BOX_ZERO, 1'b0, 1'b0}
    };

    frustum_box_cull_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_box_min_x  (box_drv.min_x),
        .i_box_min_y  (box_drv.min_y),
        .i_box_min_z  (box_drv.min_z),
        .i_box_max_x  (box_drv.max_x),
        .i_box_max_y  (box_drv.max_y),
        .i_box_max_z  (box_drv.max_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_inside_res (o_inside_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_coef clip_coef(int row, int col);
        logic [CFG_W-1:0] r;
        r = clip_regs[2 * row + col / 2];
        return (col % 2) ? $signed(r[31:0]) : $signed(r[63:32]);
    endfunction

    function automatic bit predict_inside(t_box b);
        t_coef                     pl [NUM_PLANES][4];
        t_coef                     r0, r1, r2, r3;
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [DSUM_W-1:0]  dsum;
        lo = '{b.min_x, b.min_y, b.min_z};
        hi = '{b.max_x, b.max_y, b.max_z};
        for (int c = 0; c < 4; c++) begin
            r0 = clip_coef(0, c);
            r1 = clip_coef(1, c);
            r2 = clip_coef(2, c);
            r3 = clip_coef(3, c);
            pl[0][c] = r3 + r0;
            pl[1][c] = r3 - r0;
            pl[2][c] = r3 + r1;
            pl[3][c] = r3 - r1;
            pl[4][c] = r2;
            pl[5][c] = r3 - r2;
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            dsum = pl[p][3];
            dsum = dsum <<< W_SHIFT;
            for (int a = 0; a < 3; a++)
                dsum = dsum + pl[p][a] * ((pl[p][a] >= 0) ? hi[a] : lo[a]);
            if (dsum < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_clip_set matrix_of(t_mat_sel sel);
        t_clip_set m;
        m = '{default: '0};
        case (sel)
            MAT_UNIT: begin
                m[REG_ROW0_XY] = {Q_ONE, 32'h0};
                m[REG_ROW1_XY] = {32'h0, Q_ONE};
                m[REG_ROW2_ZW] = {Q_ONE, 32'h0};
                m[REG_ROW3_ZW] = {32'h0, Q_ONE};
            end
            MAT_NEG_W: begin
                m[REG_ROW3_ZW] = {32'h0, -Q_ONE};
            end
            MAT_MAX: begin
                m = '{default: {C_MAX, C_MAX}};
            end
            MAT_MIN: begin
                m = '{default: {C_MIN, C_MIN}};
            end
            default: begin
            end
        endcase
        return m;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_q(int lim);
        int v;
        v = $urandom_range(0, 2 * lim);
        return v - lim;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coef();
        if ($urandom_range(0, 2) == 0)
            return '0;
        return rand_q(2 * Q_ONE);
    endfunction

    function automatic t_clip_set rand_matrix(bit full);
        t_clip_set m;
        for (int r = REG_ROW0_XY; r <= REG_ROW3_ZW; r++)
            m[r] = full ? {$urandom, $urandom} : {rand_coef(), rand_coef()};
        return m;
    endfunction

    // noise, inverted boxes, then well-formed boxes around the unit frustum
    function automatic t_box rand_box();
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [COORD_W-1:0] c, h;
        int                        kind;
        kind = $urandom_range(0, 19);
        for (int a = 0; a < 3; a++) begin
            if (kind < 3) begin
                lo[a] = $urandom;
                hi[a] = $urandom;
            end else begin
                c = rand_q(3 * Q_ONE);
                h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 3 * Q_HALF);
                lo[a] = (kind < 5) ? c + h : c - h;
                hi[a] = (kind < 5) ? c - h : c + h;
            end
        end
        return '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    endfunction

    task automatic load_clip(t_clip_set m);
        for (int r = REG_ROW0_XY; r <= REG_ROW3_ZW; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IDX_W'(r);
            i_cfg_data <= m[r];
            @(negedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        clip_regs = m;
    endtask

    task automatic send_box(t_box b, bit known, bit kw);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(1, 3);
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        box_drv    <= b;
        start      <= 1'b1;
        use_known  = known;
        known_want = kw;
        do @(negedge i_clk); while (!box_taken);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (inside_due.size() != 0);
    endtask

    always @(posedge i_clk) begin
        box_taken = 1'b0;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (start && !busy) begin
                inside_due.push_back(use_known ? known_want : predict_inside(box_drv));
                box_taken = 1'b1;
            end
            if (o_done) begin
                if (inside_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                             $time, o_inside_res);
                    err_count++;
                end else begin
                    want = inside_due.pop_front();
                    if (o_inside_res !== want) begin
                        $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                                 $time, want, o_inside_res);
                        err_count++;
                    end
                end
            end
            if (box_taken || o_done || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_mat_sel cur_mat;
        cur_mat = MAT_ZERO;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].mat != cur_mat) begin
                drain_results();
                load_clip(matrix_of(dir_rows[k].mat));
                cur_mat = dir_rows[k].mat;
            end
            send_box(dir_rows[k].box, dir_rows[k].known, dir_rows[k].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            load_clip(rand_matrix(ph == RAND_PHASES - 2));
            repeat (ITEMS_PER_PHASE) send_box(rand_box(), 1'b0, 1'b0);
        end

        drain_results();
        repeat (LATENCY + 4) @(negedge i_clk);
        if (err_count == 0 && inside_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fbc_pkg.sv
rtl/core/fbc_cfg.sv
rtl/core/fbc_cell.sv
rtl/core/frustum_box_cull_top.sv
tb/frustum_box_cull_top_tb.sv
